FILE: hdl/swm_pkg.sv
`default_nettype none

package swm_pkg;

  localparam int unsigned DATA_W         = 32;
  localparam int unsigned WIN_W          = 7;
  localparam logic [WIN_W-1:0] WIN_RESET = 7'd3;
  localparam int unsigned MAX_WINDOW_DEF = 64;
  localparam int unsigned APB_AW         = 3;
  localparam int unsigned APB_DW         = 32;

  // register index as taken from the word address
  localparam logic REG_WINDOW_SIZE = 1'b0;

  typedef logic signed [DATA_W-1:0] word_t;

  // one slot of a chain: occupancy flag and sample
  typedef struct packed {
    logic  vld;
    word_t val;
  } slot_t;

  // broadcast from the controller to every cell of both chains
  typedef struct packed {
    logic  ins;
    logic  evict;
    word_t sample;
    word_t oldest;
  } bcast_t;

endpackage

`default_nettype wire

FILE: hdl/swm_arrival_cell.sv
`default_nettype none

module swm_arrival_cell
  import swm_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  bcast_t ctl_i,
  input  logic   left_vld_i,
  input  slot_t  right_i,
  output slot_t  slot_o
);

  logic  vld_q, vld_d;
  word_t val_q, val_d;

  // new sample lands in the first empty cell, eviction shifts towards the head
  always_comb begin
    vld_d = vld_q;
    val_d = val_q;
    priority if (ctl_i.ins && left_vld_i && !vld_q) begin
      vld_d = 1'b1;
      val_d = ctl_i.sample;
    end else if (ctl_i.evict) begin
      vld_d = right_i.vld;
      val_d = right_i.val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign slot_o = '{vld: vld_q, val: val_q};

endmodule

`default_nettype wire

FILE: hdl/swm_sort_cell.sv
`default_nettype none

module swm_sort_cell
  import swm_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  bcast_t ctl_i,
  input  slot_t  left_i,
  input  logic   left_gt_i,
  input  slot_t  right_i,
  input  logic   right_le_i,
  output slot_t  slot_o,
  output logic   gt_o,
  output logic   le_o
);

  logic  vld_q, vld_d;
  word_t val_q, val_d;

  // empty cells count as greater so the sample lands after the last held one
  assign gt_o = !vld_q || (val_q > ctl_i.sample);
  // at or below the evicted value: the cell to the left stays put on eviction
  assign le_o = vld_q && (val_q <= ctl_i.oldest);

  always_comb begin
    vld_d = vld_q;
    val_d = val_q;
    priority if (ctl_i.ins && gt_o) begin
      if (left_gt_i) begin
        vld_d = left_i.vld;
        val_d = left_i.val;
      end else begin
        vld_d = 1'b1;
        val_d = ctl_i.sample;
      end
    end else if (ctl_i.evict && !right_le_i) begin
      vld_d = right_i.vld;
      val_d = right_i.val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign slot_o = '{vld: vld_q, val: val_q};

endmodule

`default_nettype wire

FILE: hdl/sliding_window_median.sv
// result: a full window's median is registered in ST_EMIT, after its last sample's transfer
// input: a sample that completes the window stalls the next while ST_EMIT reads the tap
//   and evicts the oldest; a sample that only fills the window does not
// after window_size is lowered, surplus held samples are evicted before a new sample is taken
// reset: window empty, window_size = 3, no result pending; the sample stores are not cleared
`default_nettype none

module sliding_window_median
  import swm_pkg::*;
#(
  parameter int unsigned MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,

  // sample stream
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [DATA_W-1:0] sample_i,

  // median stream
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] median_o,

  // register port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_AW-1:0]        paddr,
  input  logic [APB_DW-1:0]        pwdata,
  output logic [APB_DW-1:0]        prdata,
  output logic                     pready
);

  // fill count holds 0..MAX_WINDOW, tap index 0..MAX_WINDOW-1
  localparam int unsigned CW = $clog2(MAX_WINDOW + 1);
  localparam int unsigned IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned WW = (CW > WIN_W) ? CW : WIN_W;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_e;

  state_e            state_q;
  logic [CW-1:0]     fill_q;
  logic              out_valid_q;
  word_t             median_q;
  logic [WIN_W-1:0]  window_size_q;

  logic [WW-1:0]     win_ext;
  logic [CW-1:0]     win_eff;
  logic [IW-1:0]     med_idx;
  logic              need_trim;
  logic              in_xfer;
  logic              out_xfer;
  logic              cfg_wr;
  logic              reg_sel;
  bcast_t            ctl;
  word_t             med_sel;

  slot_t             arr_slot [MAX_WINDOW];
  slot_t             srt_slot [MAX_WINDOW];
  logic              srt_gt   [MAX_WINDOW];
  logic              srt_le   [MAX_WINDOW];

  // ---------------------------------------------------------------------------
  // register port: single register, low address bits ignored
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_sel = paddr[APB_AW-1];
  assign cfg_wr  = psel && penable && pwrite && pready && (reg_sel == REG_WINDOW_SIZE);
  assign prdata  = (reg_sel == REG_WINDOW_SIZE) ? APB_DW'(window_size_q) : '0;

  // window size as used: zero counts as one, large values saturate
  assign win_ext = WW'(window_size_q);
  always_comb begin
    priority if (win_ext == '0) begin
      win_eff = CW'(1);
    end else if (win_ext > WW'(MAX_WINDOW)) begin
      win_eff = CW'(MAX_WINDOW);
    end else begin
      win_eff = CW'(win_ext);
    end
  end

  // lower median sits at index ceil(w/2)-1 of the sorted chain
  assign med_idx = IW'((win_eff - CW'(1)) >> 1);

  // ---------------------------------------------------------------------------
  // handshake and chain control
  // ---------------------------------------------------------------------------
  // more samples held than the window keeps between transfers: drop the oldest first
  assign need_trim  = (fill_q >= win_eff);
  // a result is written in ST_EMIT after the transfer, so the output register must be free
  assign in_stall_o = (state_q != ST_IDLE) || need_trim || (out_valid_q && out_stall_i);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_xfer   = out_valid_q && !out_stall_i;

  assign ctl.ins    = in_xfer;
  assign ctl.evict  = (state_q == ST_EMIT) || ((state_q == ST_IDLE) && need_trim);
  assign ctl.sample = sample_i;
  assign ctl.oldest = arr_slot[0].val;

  // ---------------------------------------------------------------------------
  // cell chains
  // arrival chain: oldest sample at the head, new ones join behind the last held
  // sorted chain: ascending, inserts shift right, evictions close the gap from the right
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    logic  left_vld;
    slot_t arr_right;
    slot_t srt_left;
    logic  srt_left_gt;
    slot_t srt_right;
    logic  srt_right_le;

    if (i == 0) begin : g_head
      assign left_vld    = 1'b1;
      assign srt_left    = '0;
      assign srt_left_gt = 1'b0;
    end else begin : g_body
      assign left_vld    = arr_slot[i-1].vld;
      assign srt_left    = srt_slot[i-1];
      assign srt_left_gt = srt_gt[i-1];
    end

    if (i == MAX_WINDOW - 1) begin : g_tail
      assign arr_right    = '0;
      assign srt_right    = '0;
      assign srt_right_le = 1'b0;
    end else begin : g_mid
      assign arr_right    = arr_slot[i+1];
      assign srt_right    = srt_slot[i+1];
      assign srt_right_le = srt_le[i+1];
    end

    swm_arrival_cell u_arr (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .left_vld_i (left_vld),
      .right_i    (arr_right),
      .slot_o     (arr_slot[i])
    );

    swm_sort_cell u_srt (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .left_i     (srt_left),
      .left_gt_i  (srt_left_gt),
      .right_i    (srt_right),
      .right_le_i (srt_right_le),
      .slot_o     (srt_slot[i]),
      .gt_o       (srt_gt[i]),
      .le_o       (srt_le[i])
    );
  end

  // median tap: and-or select over the sorted chain
  always_comb begin
    med_sel = '0;
    for (int unsigned i = 0; i < MAX_WINDOW; i++) begin
      med_sel = med_sel | ((med_idx == IW'(i)) ? srt_slot[i].val : '0);
    end
  end

  // ---------------------------------------------------------------------------
  // controller: state, fill count, output register, window size register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      fill_q        <= '0;
      out_valid_q   <= 1'b0;
      median_q      <= '0;
      window_size_q <= WIN_RESET;
    end else begin
      if (cfg_wr) begin
        window_size_q <= pwdata[WIN_W-1:0];
      end

      if (ctl.ins) begin
        fill_q <= fill_q + CW'(1);
      end else if (ctl.evict) begin
        fill_q <= fill_q - CW'(1);
      end

      unique case (state_q)
        ST_IDLE: begin
          // window completes with this sample: read the tap next cycle
          if (in_xfer && (fill_q + CW'(1) == win_eff)) begin
            state_q <= ST_EMIT;
          end
          if (out_xfer) begin
            out_valid_q <= 1'b0;
          end
        end
        ST_EMIT: begin
          state_q     <= ST_IDLE;
          out_valid_q <= 1'b1;
          median_q    <= med_sel;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign median_o    = median_q;

endmodule

`default_nettype wire

FILE: hdl/swm_checker.sv
`default_nettype none

module swm_checker
  import swm_pkg::*;
(
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     in_valid_i,
  input wire logic                     in_stall_o,
  input wire logic                     out_valid_o,
  input wire logic                     out_stall_i,
  input wire logic signed [DATA_W-1:0] median_o,
  input wire logic                     psel,
  input wire logic                     penable,
  input wire logic                     pwrite,
  input wire logic [APB_AW-1:0]        paddr,
  input wire logic [APB_DW-1:0]        pwdata,
  input wire logic [APB_DW-1:0]        prdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(median_o))
    else $error("median changed or dropped while stalled");

  // a new result follows a sample transfer, with the emit state between the two
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result without a completing sample transfer");

  // the input side is held off in the cycle that produces a result
  a_emit_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("sample taken while a result was produced");

  // window size reads back as written
  a_cfg_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && (paddr[APB_AW-1] == REG_WINDOW_SIZE)
    |=> (paddr[APB_AW-1] != REG_WINDOW_SIZE) ||
        (prdata == APB_DW'($past(pwdata[WIN_W-1:0]))))
    else $error("window size readback mismatch");

endmodule

bind sliding_window_median swm_checker u_swm_checker (.*);

`default_nettype wire

FILE: sim/sliding_window_median_test.sv
`timescale 1ns / 100ps

module sliding_window_median_test;
  import swm_pkg::*;

  // register map: window_size is the only register, at byte offset 0
  localparam logic [APB_AW-1:0] WINDOW_SIZE_ADDR = 3'd0;

  localparam int unsigned HOLD_CYCLES = 400;     // long receiver hold-off
  localparam int unsigned SETTLE_CYCLES = 12;    // quiet cycles before a register write
  localparam int unsigned TAIL_CYCLES = 40;      // watch for stray medians at the end
  localparam int unsigned RANDOM_ITEMS = 750;
  localparam int unsigned MAX_REPORTS = 10;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;

  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  word_t             sample_i = '0;

  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  word_t             median_o;

  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  sliding_window_median u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_i    (sample_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .median_o    (median_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // samples waiting to be offered, filled by the sequencer below
  word_t           pending_samples[$];
  // mirror of the block: samples held oldest first, and the same samples sorted
  word_t           held_by_age[$];
  word_t           held_sorted[$];
  word_t           expected_medians[$];
  logic [WIN_W-1:0] window_reg = WIN_RESET;

  int unsigned     err_cnt = 0;
  int unsigned     queued_items = 0;
  word_t           last_sample = '0;

  // sender burst shaping
  int              burst_left;
  int              gap_left;

  // receiver stall pattern and the one long hold-off
  bit              hold_arm = 1'b0;
  bit              hold_done = 1'b0;
  int              hold_left = 0;
  int              stall_mode = 0;
  int              mode_left = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("[sliding_window_median] ERROR");
    $finish;
  end

  task automatic flag_error(input string msg);
    if (err_cnt < MAX_REPORTS) $display("mismatch: %s", msg);
    err_cnt++;
  endtask

  // register value mapped onto the window actually used: zero acts as one,
  // anything beyond the store depth saturates
  function automatic int eff_window(input logic [WIN_W-1:0] w);
    if (w == 0) return 1;
    if (w > MAX_WINDOW_DEF) return MAX_WINDOW_DEF;
    return int'(w);
  endfunction

  // drop the oldest held sample from both views; with equal values only one goes
  task automatic drop_oldest();
    word_t old;
    int    idx;
    old = held_by_age.pop_front();
    idx = 0;
    while (idx < held_sorted.size() - 1 && held_sorted[idx] != old) idx++;
    held_sorted.delete(idx);
  endtask

  // one accepted sample: trim to w-1, insert in order, emit lower median when full
  task automatic predict_median(input word_t smp);
    int w;
    int pos;
    w = eff_window(window_reg);
    while (held_by_age.size() > w - 1) drop_oldest();
    held_by_age.push_back(smp);
    pos = held_sorted.size();
    while (pos > 0 && held_sorted[pos-1] > smp) pos--;
    held_sorted.insert(pos, smp);
    if (held_by_age.size() >= w) begin
      expected_medians.push_back(held_sorted[(w + 1) / 2 - 1]);
      drop_oldest();
    end
  endtask

  // sample driver: bursts of random length with random gaps, payload held while stalled
  always @(posedge clk_i or negedge rst_ni) begin : sample_driver
    logic  nxt_valid;
    word_t nxt_sample;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      burst_left = $urandom_range(1, 40);
      gap_left = 0;
    end else begin
      nxt_valid = in_valid_i;
      nxt_sample = sample_i;
      if (in_valid_i && !in_stall_o) predict_median(sample_i);
      if (!in_valid_i || !in_stall_o) begin
        nxt_valid = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_samples.size() > 0) begin
          nxt_valid = 1'b1;
          nxt_sample = pending_samples.pop_front();
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = $urandom_range(1, 8);
          end
        end
      end
      in_valid_i <= nxt_valid;
      sample_i <= nxt_sample;
    end
  end

  // receiver stall: changing duty cycle, no-stall stretches, one long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin : median_stall
    logic stall_nxt;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      stall_nxt = 1'b0;
      if (hold_left > 0) begin
        hold_left--;
        stall_nxt = 1'b1;
        if (hold_left == 0) hold_done = 1'b1;
      end else if (hold_arm && !hold_done) begin
        hold_left = HOLD_CYCLES;
        stall_nxt = 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left = $urandom_range(10, 80);
        end
        mode_left--;
        case (stall_mode)
          0: stall_nxt = 1'b0;
          1: stall_nxt = ($urandom_range(0, 3) == 0);
          2: stall_nxt = ($urandom_range(0, 1) == 0);
          default: stall_nxt = ($urandom_range(0, 3) != 0);
        endcase
      end
      out_stall_i <= stall_nxt;
    end
  end

  // median monitor: every transfer is checked against the oldest expectation
  always @(posedge clk_i) begin : median_monitor
    word_t exp_med;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_medians.size() == 0) begin
        flag_error($sformatf("unexpected median %0d", median_o));
      end else begin
        exp_med = expected_medians.pop_front();
        if (median_o !== exp_med)
          flag_error($sformatf("median expected %0d got %0d", exp_med, median_o));
      end
    end
  end

  // mixed sample source: full-range noise, tight clusters for ties, extremes, repeats
  function automatic word_t pick_sample();
    word_t v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: v = word_t'($urandom);
      5, 6, 7:       v = word_t'($urandom_range(0, 8)) - 4;
      8: begin
        case ($urandom_range(0, 3))
          0: v = 32'sh8000_0000;
          1: v = 32'sh7FFF_FFFF;
          2: v = '0;
          default: v = '1;
        endcase
      end
      default: v = last_sample;
    endcase
    last_sample = v;
    return v;
  endfunction

  task automatic queue_sample(input word_t v);
    pending_samples.push_back(v);
    queued_items++;
  endtask

  // block is idle once every sample has gone in and every median has come out
  task automatic wait_idle();
    while (pending_samples.size() != 0 || in_valid_i || expected_medians.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // apb write of window_size followed by a read back
  task automatic set_window(input logic [WIN_W-1:0] w);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= WINDOW_SIZE_ADDR;
    pwdata <= {{(APB_DW-WIN_W){1'b0}}, w};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    // write lands at this edge; go straight into the read setup
    window_reg = w;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== {{(APB_DW-WIN_W){1'b0}}, w})
      flag_error($sformatf("window_size read back %0d, wrote %0d", prdata, w));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic random_phase(input logic [WIN_W-1:0] w, input bit do_hold);
    int n;
    int ew;
    wait_idle();
    set_window(w);
    ew = eff_window(w);
    n = $urandom_range(20, 60) + ((ew > 12) ? ew + 30 : 0) + (do_hold ? 150 : 0);
    hold_arm = do_hold;
    repeat (n) queue_sample(pick_sample());
  endtask

  // sequencer
  initial begin : sequencer
    logic [WIN_W-1:0] phase_windows[$];
    int               start_items;
    int               k;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset window of three, extremes, ties and alternating bit patterns
    queue_sample(32'sh8000_0000);
    queue_sample(32'sh7FFF_FFFF);
    queue_sample(32'sh0000_0000);
    queue_sample(32'shFFFF_FFFF);
    queue_sample(32'sh0000_0001);
    queue_sample(32'sd5);
    queue_sample(32'sd5);
    queue_sample(32'sd5);
    queue_sample(32'shAAAA_AAAA);
    queue_sample(32'sh5555_5555);
    queue_sample(-32'sd7);

    // pass-through with a window of one
    wait_idle();
    set_window(7'd1);
    queue_sample(32'sh7FFF_FFFF);
    queue_sample(32'sh8000_0000);

    // zero window behaves as one
    wait_idle();
    set_window(7'd0);
    queue_sample(32'shFFFF_FFFF);
    queue_sample(32'sd2);

    // partly fill a window of six, then shrink to two: surplus held samples evicted
    wait_idle();
    set_window(7'd6);
    queue_sample(32'sd10);
    queue_sample(-32'sd3);
    queue_sample(32'sd10);
    queue_sample(32'sd0);
    queue_sample(32'sh8000_0000);
    wait_idle();
    set_window(7'd2);
    queue_sample(32'sd4);
    queue_sample(32'sd4);

    // grow from two to four with one sample held, window fills further
    wait_idle();
    set_window(7'd4);
    queue_sample(32'sd9);
    queue_sample(-32'sd9);
    queue_sample(32'sd1);

    // random phases: fixed list covering shrink, grow, full depth and saturation first
    start_items = queued_items;
    phase_windows = '{7'd5, 7'd2, 7'd3, 7'd9, 7'd64, 7'd127, 7'd65, 7'd1, 7'd0,
                      7'd100, 7'd2, 7'd63};
    k = 0;
    while (queued_items - start_items < RANDOM_ITEMS) begin
      if (k < phase_windows.size())
        random_phase(phase_windows[k], (k == 2));
      else if ($urandom_range(0, 3) == 0)
        random_phase(WIN_W'($urandom_range(0, 127)), 1'b0);
      else
        random_phase(WIN_W'($urandom_range(1, 9)), 1'b0);
      k++;
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("[sliding_window_median] OK");
    end else begin
      $display("[sliding_window_median] ERROR");
    end
    $finish;
  end

endmodule
